// File: rtl/dgr_pkg.sv
// Shared types, register indexes and arithmetic helpers for the dithered gradient unit.
`timescale 1ns / 1ps

package dgr_pkg;

  localparam int SCREEN_HEIGHT_DEF = 240;

  localparam logic [2:0] REG_STOP_COLOR_0 = 3'd0;
  localparam logic [2:0] REG_STOP_COLOR_1 = 3'd1;
  localparam logic [2:0] REG_STOP_COLOR_2 = 3'd2;
  localparam logic [2:0] REG_STOP_COLOR_3 = 3'd3;
  localparam logic [2:0] REG_STOP_POS_0   = 3'd4;
  localparam logic [2:0] REG_STOP_POS_1   = 3'd5;
  localparam logic [2:0] REG_STOP_POS_2   = 3'd6;
  localparam logic [2:0] REG_STOP_POS_3   = 3'd7;

  localparam int POS0_RESET = 0;
  localparam int POS1_RESET = 70;
  localparam int POS2_RESET = 150;
  localparam int POS3_RESET = 255;

  // 4x4 ordered dither thresholds, indexed {row[1:0], column[1:0]}
  localparam logic [3:0] BAYER_TAB [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  // Multiplier for an exact divide by 255 of any 16-bit value: (p * 0x8081) >> 23
  localparam logic [15:0] RECIP_255 = 16'h8081;

  typedef struct packed {
    logic [23:0] color_a;
    logic [23:0] color_b;
    logic [3:0]  bayer;
  } dgr_carry_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] bayer;
  } dgr_rgb_t;

  function automatic logic [3:0] bayer_at(logic [1:0] row, logic [1:0] col);
    return BAYER_TAB[{row, col}];
  endfunction

  // a * (255 - mix) + b * mix + 127, never above 65152
  function automatic logic [15:0] blend_sum(logic [7:0] a, logic [7:0] b, logic [7:0] mix);
    logic [15:0] pa;
    logic [15:0] pb;
    pa = {8'd0, a} * {8'd0, 8'd255 - mix};
    pb = {8'd0, b} * {8'd0, mix};
    return pa + pb + 16'd127;
  endfunction

  function automatic logic [7:0] div255(logic [15:0] p);
    logic [31:0] prod;
    prod = {16'd0, p} * {16'd0, RECIP_255};
    return prod[30:23];
  endfunction

  // step 8: threshold is ((2*bayer+1)*8)>>5, i.e. bayer>>1
  function automatic logic [4:0] quant5(logic [7:0] c, logic [3:0] bayer);
    logic [5:0] q;
    q = {1'b0, c[7:3]} + ((c[2:0] > bayer[3:1]) ? 6'd1 : 6'd0);
    return q[5] ? 5'd31 : q[4:0];
  endfunction

  // step 4: threshold is ((2*bayer+1)*4)>>5, i.e. bayer>>2
  function automatic logic [5:0] quant6(logic [7:0] c, logic [3:0] bayer);
    logic [6:0] q;
    q = {1'b0, c[7:2]} + ((c[1:0] > bayer[3:2]) ? 7'd1 : 7'd0);
    return q[6] ? 6'd63 : q[5:0];
  endfunction

endpackage

// File: rtl/dgr_select.sv
// Stop selection stage: picks the bracketing stops, row offset, span and dither threshold.
`timescale 1ns / 1ps

module dgr_select import dgr_pkg::*; #(
  parameter int ROW_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [8:0]       pixel_x,
  input  logic [7:0]       pixel_y,
  input  logic [ROW_W-1:0] row0,
  input  logic [ROW_W-1:0] row1,
  input  logic [ROW_W-1:0] row2,
  input  logic [ROW_W-1:0] row3,
  input  logic [23:0]      color0,
  input  logic [23:0]      color1,
  input  logic [23:0]      color2,
  input  logic [23:0]      color3,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [7:0]       dn_offset,
  output logic [ROW_W-1:0] dn_span,
  output dgr_carry_t       dn_carry
);

  localparam int CMPW = ROW_W + 8;

  logic             valid_r;
  logic [7:0]       offset_r;
  logic [ROW_W-1:0] span_r;
  dgr_carry_t       carry_r;

  logic [7:0]       offset_nxt;
  logic [ROW_W-1:0] span_nxt;
  dgr_carry_t       carry_nxt;
  logic [ROW_W-1:0] lo;
  logic [ROW_W-1:0] hi;
  logic [CMPW-1:0]  yw;
  logic [CMPW-1:0]  diff;
  logic             at_top;
  logic             at_bottom;
  logic             in_first;
  logic             in_second;
  logic             advance;

  assign advance  = !valid_r || dn_ready;
  assign up_ready = advance;

  always_comb begin
    yw        = CMPW'(pixel_y);
    at_top    = yw <= CMPW'(row0);
    at_bottom = yw >= CMPW'(row3);
    in_first  = yw <= CMPW'(row1);
    in_second = yw <= CMPW'(row2);
    lo        = row0;
    hi        = row1;
    carry_nxt.bayer = bayer_at(pixel_y[1:0], pixel_x[1:0]);
    // end rows: both colours equal and zero offset make the blend return the stop colour
    priority if (at_top) begin
      carry_nxt.color_a = color0;
      carry_nxt.color_b = color0;
    end else if (at_bottom) begin
      carry_nxt.color_a = color3;
      carry_nxt.color_b = color3;
    end else if (in_first) begin
      carry_nxt.color_a = color0;
      carry_nxt.color_b = color1;
      lo = row0;
      hi = row1;
    end else if (in_second) begin
      carry_nxt.color_a = color1;
      carry_nxt.color_b = color2;
      lo = row1;
      hi = row2;
    end else begin
      carry_nxt.color_a = color2;
      carry_nxt.color_b = color3;
      lo = row2;
      hi = row3;
    end
    diff = yw - CMPW'(lo);
    if (at_top || at_bottom) begin
      offset_nxt = 8'd0;
      span_nxt   = ROW_W'(1);
    end else begin
      offset_nxt = diff[7:0];
      span_nxt   = hi - lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      offset_r <= offset_nxt;
      span_r   <= span_nxt;
      carry_r  <= carry_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_offset = offset_r;
  assign dn_span   = span_r;
  assign dn_carry  = carry_r;

endmodule

// File: rtl/dgr_divider.sv
// Four-stage restoring divider: mix = offset * 255 / span, two quotient bits per stage.
`timescale 1ns / 1ps

module dgr_divider import dgr_pkg::*; #(
  parameter int ROW_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [7:0]       up_offset,
  input  logic [ROW_W-1:0] up_span,
  input  dgr_carry_t       up_carry,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [7:0]       dn_mix,
  output dgr_carry_t       dn_carry
);

  localparam int STAGES = 4;
  localparam int CW     = ROW_W + 16;

  logic [STAGES-1:0] valid_r;
  logic [15:0]       rem_r   [STAGES];
  logic [7:0]        quo_r   [STAGES];
  logic [ROW_W-1:0]  span_r  [STAGES];
  dgr_carry_t        carry_r [STAGES];

  logic [STAGES-1:0] stage_in_valid;
  logic [15:0]       rem_in   [STAGES];
  logic [7:0]        quo_in   [STAGES];
  logic [ROW_W-1:0]  span_in  [STAGES];
  dgr_carry_t        carry_in [STAGES];
  logic [STAGES:0]   ready;
  logic [STAGES-1:0] advance;

  assign ready[STAGES] = dn_ready;

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      localparam int K0 = 7 - 2 * s;
      localparam int K1 = 6 - 2 * s;

      logic [CW-1:0] rem_mid;
      logic [CW-1:0] rem_fin;
      logic [CW-1:0] sh0;
      logic [CW-1:0] sh1;
      logic [7:0]    quo_nxt;
      logic [15:0]   rem_nxt;

      if (s == 0) begin : g_head
        // offset * 255 as (offset << 8) - offset
        assign rem_in[s]         = {up_offset, 8'd0} - {8'd0, up_offset};
        assign quo_in[s]         = 8'd0;
        assign span_in[s]        = up_span;
        assign carry_in[s]       = up_carry;
        assign stage_in_valid[s] = up_valid;
      end else begin : g_body
        assign rem_in[s]         = rem_r[s-1];
        assign quo_in[s]         = quo_r[s-1];
        assign span_in[s]        = span_r[s-1];
        assign carry_in[s]       = carry_r[s-1];
        assign stage_in_valid[s] = valid_r[s-1];
      end

      assign advance[s] = !valid_r[s] || ready[s+1];
      assign ready[s]   = advance[s];

      always_comb begin
        sh0     = CW'(span_in[s]) << K0;
        sh1     = CW'(span_in[s]) << K1;
        quo_nxt = quo_in[s];
        rem_mid = CW'(rem_in[s]);
        if (rem_mid >= sh0) begin
          rem_mid     = rem_mid - sh0;
          quo_nxt[K0] = 1'b1;
        end
        rem_fin = rem_mid;
        if (rem_fin >= sh1) begin
          rem_fin     = rem_fin - sh1;
          quo_nxt[K1] = 1'b1;
        end
        rem_nxt = rem_fin[15:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[s] <= 1'b0;
        end else if (advance[s]) begin
          valid_r[s] <= stage_in_valid[s];
        end
      end

      always_ff @(posedge clk) begin
        if (advance[s] && stage_in_valid[s]) begin
          rem_r[s]   <= rem_nxt;
          quo_r[s]   <= quo_nxt;
          span_r[s]  <= span_in[s];
          carry_r[s] <= carry_in[s];
        end
      end
    end
  endgenerate

  assign up_ready = ready[0];
  assign dn_valid = valid_r[STAGES-1];
  assign dn_mix   = quo_r[STAGES-1];
  assign dn_carry = carry_r[STAGES-1];

endmodule

// File: rtl/dgr_blend.sv
// Two-stage channel blend: weighted sum, then exact divide by 255 via reciprocal multiply.
`timescale 1ns / 1ps

module dgr_blend import dgr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [7:0] up_mix,
  input  dgr_carry_t up_carry,
  output logic       dn_valid,
  input  logic       dn_ready,
  output dgr_rgb_t   dn_rgb
);

  logic        sum_valid_r;
  logic [15:0] sum_red_r;
  logic [15:0] sum_green_r;
  logic [15:0] sum_blue_r;
  logic [3:0]  sum_bayer_r;
  logic        rgb_valid_r;
  dgr_rgb_t    rgb_r;

  logic        sum_advance;
  logic        rgb_advance;
  dgr_rgb_t    rgb_nxt;

  assign rgb_advance = !rgb_valid_r || dn_ready;
  assign sum_advance = !sum_valid_r || rgb_advance;
  assign up_ready    = sum_advance;

  always_comb begin
    rgb_nxt.red   = div255(sum_red_r);
    rgb_nxt.green = div255(sum_green_r);
    rgb_nxt.blue  = div255(sum_blue_r);
    rgb_nxt.bayer = sum_bayer_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r <= 1'b0;
      rgb_valid_r <= 1'b0;
    end else begin
      if (sum_advance) begin
        sum_valid_r <= up_valid;
      end
      if (rgb_advance) begin
        rgb_valid_r <= sum_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_advance && up_valid) begin
      sum_red_r   <= blend_sum(up_carry.color_a[23:16], up_carry.color_b[23:16], up_mix);
      sum_green_r <= blend_sum(up_carry.color_a[15:8], up_carry.color_b[15:8], up_mix);
      sum_blue_r  <= blend_sum(up_carry.color_a[7:0], up_carry.color_b[7:0], up_mix);
      sum_bayer_r <= up_carry.bayer;
    end
    if (rgb_advance && sum_valid_r) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign dn_valid = rgb_valid_r;
  assign dn_rgb   = rgb_r;

endmodule

// File: rtl/dgr_quant.sv
// Output stage: ordered-dither quantisation to 5/6/5 bits and the result register.
`timescale 1ns / 1ps

module dgr_quant import dgr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  dgr_rgb_t    up_rgb,
  output logic        dn_valid,
  input  logic        dn_stall,
  output logic [15:0] dn_pixel
);

  logic        valid_r;
  logic [15:0] pixel_r;
  logic [15:0] pixel_nxt;
  logic        advance;

  assign advance  = !valid_r || !dn_stall;
  assign up_ready = advance;

  always_comb begin
    pixel_nxt = {quant5(up_rgb.red, up_rgb.bayer),
                 quant6(up_rgb.green, up_rgb.bayer),
                 quant5(up_rgb.blue, up_rgb.bayer)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_pixel = pixel_r;

endmodule

// File: rtl/dithered_gradient_rgb565_unit.sv
// Top level of the dithered four-stop vertical gradient pixel unit (RGB565 out).
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  in_pixel_x[8:0], in_pixel_y[7:0]
//   out      source     out_valid/out_stall  out_pixel_rgb565[15:0]
//   cfg      sink       cfg_we               cfg_index[2:0], cfg_data[23:0]
//
// One request per clock is taken while the output is not stalled; the result is on the
// outputs from the last of 8 register stages (1 select stage, 4 divider stages of two
// quotient bits, 2 blend stages, 1 output stage).
// Each stage advances when it is empty or the next one takes its request, so bubbles
// close up and a stall at the output holds every occupied stage without loss.
// Synchronous active-low reset empties the pipeline and restores the stop registers;
// stop rows are scaled at write time, so a request may follow a write in the next cycle.
`timescale 1ns / 1ps

module dithered_gradient_rgb565_unit import dgr_pkg::*; #(
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [8:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_rgb565,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int PW    = ROW_W + 8;

  localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'((POS0_RESET * SCREEN_HEIGHT) >> 8);
  localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'((POS1_RESET * SCREEN_HEIGHT) >> 8);
  localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'((POS2_RESET * SCREEN_HEIGHT) >> 8);
  localparam logic [ROW_W-1:0] ROW3_RESET = ROW_W'((POS3_RESET * SCREEN_HEIGHT) >> 8);

  logic [23:0]      color0_r;
  logic [23:0]      color1_r;
  logic [23:0]      color2_r;
  logic [23:0]      color3_r;
  logic [ROW_W-1:0] row0_r;
  logic [ROW_W-1:0] row1_r;
  logic [ROW_W-1:0] row2_r;
  logic [ROW_W-1:0] row3_r;

  logic [PW-1:0]    row_prod;
  logic [ROW_W-1:0] row_nxt;

  logic             sel_valid;
  logic             sel_ready;
  logic [7:0]       sel_offset;
  logic [ROW_W-1:0] sel_span;
  dgr_carry_t       sel_carry;
  logic             in_ready;

  logic             div_valid;
  logic             div_ready;
  logic [7:0]       div_mix;
  dgr_carry_t       div_carry;

  logic             bl_valid;
  logic             bl_ready;
  dgr_rgb_t         bl_rgb;

  logic             q_ready;

  // stop position to row: (pos * height) >> 8
  always_comb begin
    row_prod = PW'(cfg_data[7:0]) * PW'(SCREEN_HEIGHT);
    row_nxt  = row_prod[PW-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color0_r <= 24'd0;
      color1_r <= 24'd0;
      color2_r <= 24'd0;
      color3_r <= 24'd0;
      row0_r   <= ROW0_RESET;
      row1_r   <= ROW1_RESET;
      row2_r   <= ROW2_RESET;
      row3_r   <= ROW3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STOP_COLOR_0: color0_r <= cfg_data;
        REG_STOP_COLOR_1: color1_r <= cfg_data;
        REG_STOP_COLOR_2: color2_r <= cfg_data;
        REG_STOP_COLOR_3: color3_r <= cfg_data;
        REG_STOP_POS_0:   row0_r   <= row_nxt;
        REG_STOP_POS_1:   row1_r   <= row_nxt;
        REG_STOP_POS_2:   row2_r   <= row_nxt;
        REG_STOP_POS_3:   row3_r   <= row_nxt;
        default:          ;
      endcase
    end
  end

  dgr_select #(
    .ROW_W (ROW_W)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .row0      (row0_r),
    .row1      (row1_r),
    .row2      (row2_r),
    .row3      (row3_r),
    .color0    (color0_r),
    .color1    (color1_r),
    .color2    (color2_r),
    .color3    (color3_r),
    .dn_valid  (sel_valid),
    .dn_ready  (sel_ready),
    .dn_offset (sel_offset),
    .dn_span   (sel_span),
    .dn_carry  (sel_carry)
  );

  assign in_stall = !in_ready;

  dgr_divider #(
    .ROW_W (ROW_W)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (sel_valid),
    .up_ready  (sel_ready),
    .up_offset (sel_offset),
    .up_span   (sel_span),
    .up_carry  (sel_carry),
    .dn_valid  (div_valid),
    .dn_ready  (div_ready),
    .dn_mix    (div_mix),
    .dn_carry  (div_carry)
  );

  dgr_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_mix   (div_mix),
    .up_carry (div_carry),
    .dn_valid (bl_valid),
    .dn_ready (bl_ready),
    .dn_rgb   (bl_rgb)
  );

  dgr_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (bl_valid),
    .up_ready (q_ready),
    .up_rgb   (bl_rgb),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_pixel (out_pixel_rgb565)
  );

  assign bl_ready = q_ready;

endmodule
